// ----- rtl/bre_pkg.sv -----
// ----------------------------------------------------------------------------
// bre_pkg
// Types and constants shared by the BMP RLE8 line encoder.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int unsigned RUN_CAP = 255;
    localparam int unsigned MIN_ENCODED_RUN = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CLOSE,
        ST_LIT_ADD,
        ST_FL_HEAD,
        ST_FL_BODY,
        ST_FL_PAD,
        ST_RUN_PAIR,
        ST_NEXT_RUN,
        ST_ROW_MARK,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/bmp_rle8_line_encoder_top.sv -----
// ----------------------------------------------------------------------------
// bmp_rle8_line_encoder_top
// BMP RLE8 encoder for a stream of 8-bit palette pixels.
// ----------------------------------------------------------------------------
// One pixel is taken at a time; s_ready is high only while the encoder is idle.
// A pixel that only extends the open run causes no result. A pixel that closes
// a run starts the close: it writes bytes into the literal memory (up to
// three) or, after a literal flush, a count/value pair. A flush writes a
// two-byte header, the stored bytes and a pad byte if the count is odd (a
// flush of one or two bytes writes each byte as a pair with a count of one).
// Row end adds a second close, a flush and an end-of-line marker (and an
// end-of-bitmap marker with image end). Encoded bytes are packed up to eight
// to a transfer; the core waits only when a ninth byte, or a pixel's last
// word, meets a full output register that is not being taken. The literal
// memory has one write and one read port with a registered read.
module bmp_rle8_line_encoder_top import bre_pkg::*; #(
    parameter int unsigned LITERAL_DEPTH = 254
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel,
    input  logic        s_row_end,
    input  logic        s_image_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_bytes,
    output logic [3:0]  m_out_count,
    output logic        m_out_last
);

    localparam int unsigned AW = $clog2(LITERAL_DEPTH);

    logic [7:0] lit_mem [LITERAL_DEPTH];
    logic [7:0] rd_data_reg;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;          // state after a flush
    logic tail_reg, tail_next;          // close at row end
    logic [7:0] px_reg, px_next;
    logic row_reg, row_next, img_reg, img_next;
    logic [7:0] lit_cnt_reg, lit_cnt_next;
    logic [7:0] run_val_reg, run_val_next;
    logic [7:0] run_cnt_reg, run_cnt_next;
    logic [7:0] k_reg, k_next;          // flush index
    logic [1:0] hsub_reg, hsub_next;    // byte index within a group

    logic [63:0] acc_reg, acc_next;
    logic [3:0]  acc_n_reg, acc_n_next;

    logic        mv_reg;
    logic [63:0] mb_reg;
    logic [3:0]  mc_reg;
    logic        ml_reg;

    logic       push;
    logic [7:0] push_byte;
    logic       emit_now;
    logic       emit_last;
    logic       wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0] wr_data;
    logic       out_free;
    logic       can_push;
    logic       small_flush;
    logic       run_ext;

    assign out_free = !mv_reg || m_ready;
    assign can_push = (acc_n_reg != 4'd8) || out_free;
    assign s_ready  = (state_reg == ST_IDLE);
    assign small_flush = (lit_cnt_reg <= 8'd2);
    assign run_ext = (run_cnt_reg != 8'd0) && (px_reg == run_val_reg)
                     && (run_cnt_reg != 8'(RUN_CAP));
    assign wr_addr = lit_cnt_reg[AW-1:0];
    assign wr_data = run_val_reg;
    assign rd_addr = k_next[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lit_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= lit_mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        tail_next  = tail_reg;
        px_next = px_reg; row_next = row_reg; img_next = img_reg;
        lit_cnt_next = lit_cnt_reg;
        run_val_next = run_val_reg;
        run_cnt_next = run_cnt_reg;
        k_next = k_reg;
        hsub_next = hsub_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    px_next = s_pixel; row_next = s_row_end; img_next = s_image_end;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (run_ext) begin
                    run_cnt_next = run_cnt_reg + 8'd1;
                    tail_next = 1'b1;
                    state_next = row_reg ? ST_CLOSE : ST_IDLE;
                end else begin
                    tail_next = 1'b0;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                hsub_next = 2'd0;
                if (run_cnt_reg == 8'd0) begin
                    state_next = ST_NEXT_RUN;
                end else if (run_cnt_reg > 8'(MIN_ENCODED_RUN)) begin
                    ret_next = ST_RUN_PAIR;
                    state_next = (lit_cnt_reg != 8'd0) ? ST_FL_HEAD : ST_RUN_PAIR;
                end else begin
                    state_next = ST_LIT_ADD;
                end
            end
            ST_LIT_ADD: begin
                lit_cnt_next = lit_cnt_reg + 8'd1;
                run_cnt_next = run_cnt_reg - 8'd1;
                if (lit_cnt_reg == 8'(LITERAL_DEPTH - 1)) begin
                    ret_next = (run_cnt_reg == 8'd1) ? ST_NEXT_RUN : ST_LIT_ADD;
                    hsub_next = 2'd0;
                    state_next = ST_FL_HEAD;
                end else if (run_cnt_reg == 8'd1) begin
                    state_next = ST_NEXT_RUN;
                end
            end
            ST_FL_HEAD: begin
                k_next = 8'd0;
                if (small_flush) begin
                    hsub_next = 2'd0;
                    state_next = ST_FL_BODY;
                end else if (can_push) begin
                    if (hsub_reg == 2'd1) begin
                        hsub_next = 2'd0;
                        state_next = ST_FL_BODY;
                    end else begin
                        hsub_next = 2'd1;
                    end
                end
            end
            ST_FL_BODY: begin
                if (can_push) begin
                    if (small_flush && !hsub_reg[0]) begin
                        hsub_next = 2'd1;
                    end else begin
                        hsub_next = 2'd0;
                        k_next = k_reg + 8'd1;
                        if (k_reg + 8'd1 == lit_cnt_reg) begin
                            if (!small_flush && lit_cnt_reg[0]) begin
                                state_next = ST_FL_PAD;
                            end else begin
                                lit_cnt_next = 8'd0;
                                state_next = ret_reg;
                            end
                        end
                    end
                end
            end
            ST_FL_PAD: begin
                if (can_push) begin
                    lit_cnt_next = 8'd0;
                    hsub_next = 2'd0;
                    state_next = ret_reg;
                end
            end
            ST_RUN_PAIR: begin
                if (can_push) begin
                    if (hsub_reg == 2'd1) begin
                        hsub_next = 2'd0;
                        run_cnt_next = 8'd0;
                        state_next = ST_NEXT_RUN;
                    end else begin
                        hsub_next = 2'd1;
                    end
                end
            end
            ST_NEXT_RUN: begin
                hsub_next = 2'd0;
                if (!tail_reg) begin
                    run_val_next = px_reg;
                    run_cnt_next = 8'd1;
                    tail_next = 1'b1;
                    state_next = row_reg ? ST_CLOSE : ST_EMIT;
                end else begin
                    ret_next = ST_ROW_MARK;
                    state_next = (lit_cnt_reg != 8'd0) ? ST_FL_HEAD : ST_ROW_MARK;
                end
            end
            ST_ROW_MARK: begin
                if (can_push) begin
                    hsub_next = hsub_reg + 2'd1;
                    if (hsub_reg == (img_reg ? 2'd3 : 2'd1)) begin
                        hsub_next = 2'd0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free || acc_n_reg == 4'd0) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // byte production
    always_comb begin
        push = 1'b0;
        push_byte = 8'd0;
        wr_en = 1'b0;
        emit_last = 1'b0;
        unique case (state_reg)
            ST_LIT_ADD: wr_en = 1'b1;
            ST_FL_HEAD: begin
                if (!small_flush) begin
                    push = can_push;
                    push_byte = (hsub_reg == 2'd0) ? 8'd0 : lit_cnt_reg;
                end
            end
            ST_FL_BODY: begin
                push = can_push;
                push_byte = (small_flush && !hsub_reg[0]) ? 8'd1 : rd_data_reg;
            end
            ST_FL_PAD: push = can_push;
            ST_RUN_PAIR: begin
                push = can_push;
                push_byte = (hsub_reg == 2'd0) ? run_cnt_reg : run_val_reg;
            end
            ST_ROW_MARK: begin
                push = can_push;
                push_byte = (hsub_reg == 2'd3) ? 8'd1 : 8'd0;
            end
            ST_EMIT: emit_last = 1'b1;
            default: ;
        endcase
        emit_now = (push && acc_n_reg == 4'd8)
                   || (state_reg == ST_EMIT && acc_n_reg != 4'd0 && out_free);
    end

    // packing; a full word leaves when the next byte arrives or when the pixel's work ends
    always_comb begin
        acc_next = acc_reg;
        acc_n_next = acc_n_reg;
        if (emit_now) begin
            acc_next = 64'd0;
            acc_n_next = 4'd0;
        end
        if (push) begin
            acc_next[{acc_n_next[2:0], 3'b000} +: 8] = push_byte;
            acc_n_next = acc_n_next + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            tail_reg <= 1'b0;
            lit_cnt_reg <= 8'd0;
            run_val_reg <= 8'd0;
            run_cnt_reg <= 8'd0;
            acc_reg <= 64'd0;
            acc_n_reg <= 4'd0;
            mv_reg <= 1'b0;
            k_reg <= 8'd0;
            hsub_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            tail_reg <= tail_next;
            lit_cnt_reg <= lit_cnt_next;
            run_val_reg <= run_val_next;
            run_cnt_reg <= run_cnt_next;
            acc_reg <= acc_next;
            acc_n_reg <= acc_n_next;
            k_reg <= k_next;
            hsub_reg <= hsub_next;
            if (emit_now) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
        px_reg <= px_next;
        row_reg <= row_next;
        img_reg <= img_next;
        if (emit_now) begin
            mb_reg <= acc_reg;
            mc_reg <= acc_n_reg;
            ml_reg <= emit_last;
        end
    end

    assign m_valid = mv_reg;
    assign m_out_bytes = mb_reg;
    assign m_out_count = mc_reg;
    assign m_out_last = ml_reg;

endmodule

// ----- tb/sv/bmp_rle8_line_encoder_checker.sv -----
// ----------------------------------------------------------------------------
// bmp_rle8_line_encoder_checker
// Watches the pixel and result channels of the RLE8 encoder, predicts the
// packed BI_RLE8 byte stream of every accepted pixel and compares each
// accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module bmp_rle8_line_encoder_checker import bre_pkg::*; #(
    parameter int unsigned LITERAL_DEPTH = 254
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_pixel,
    input  logic        s_row_end,
    input  logic        s_image_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_out_bytes,
    input  logic [3:0]  m_out_count,
    input  logic        m_out_last,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
    } rle_word_t;

    rle_word_t   word_q[$];
    logic [7:0]  lit_mem[LITERAL_DEPTH];
    int unsigned lit_cnt;
    logic [7:0]  run_val;
    int unsigned run_cnt;
    logic [7:0]  byte_q[$];

    function automatic void put_byte(logic [7:0] b);
        byte_q.insert(byte_q.size(), b);
    endfunction

    function automatic void flush_lits();
        if (lit_cnt == 0) return;
        if (lit_cnt <= 2) begin
            for (int i = 0; i < lit_cnt; i++) begin
                put_byte(8'd1);
                put_byte(lit_mem[i]);
            end
        end else begin
            put_byte(8'd0);
            put_byte(8'(lit_cnt));
            for (int i = 0; i < lit_cnt; i++) put_byte(lit_mem[i]);
            if (lit_cnt[0]) put_byte(8'd0);
        end
        lit_cnt = 0;
    endfunction

    function automatic void add_lit(logic [7:0] b);
        if (lit_cnt < LITERAL_DEPTH) begin
            lit_mem[lit_cnt] = b;
            lit_cnt++;
        end
        if (lit_cnt >= LITERAL_DEPTH) flush_lits();
    endfunction

    function automatic void close_run();
        if (run_cnt == 0) return;
        if (run_cnt > MIN_ENCODED_RUN) begin
            flush_lits();
            put_byte(8'(run_cnt));
            put_byte(run_val);
        end else begin
            for (int k = 0; k < run_cnt; k++) add_lit(run_val);
        end
        run_cnt = 0;
    endfunction

    function automatic void encode_pixel(logic [7:0] px, logic row_end, logic img_end);
        rle_word_t w;
        int n;
        byte_q.delete();
        if (run_cnt != 0 && px == run_val && run_cnt < RUN_CAP) begin
            run_cnt++;
        end else begin
            close_run();
            run_val = px;
            run_cnt = 1;
        end
        if (row_end) begin
            close_run();
            flush_lits();
            put_byte(8'd0);
            put_byte(8'd0);
            if (img_end) begin
                put_byte(8'd0);
                put_byte(8'd1);
            end
        end
        while (byte_q.size() > 0) begin
            n = (byte_q.size() > 8) ? 8 : byte_q.size();
            w = '0;
            for (int k = 0; k < n; k++) w.bytes[8*k +: 8] = byte_q.pop_front();
            w.count = 4'(n);
            w.last  = (byte_q.size() == 0);
            word_q.insert(word_q.size(), w);
        end
    endfunction

    always @(posedge aclk) begin
        rle_word_t w;
        if (!aresetn) begin
            lit_cnt = 0;
            run_val = '0;
            run_cnt = 0;
            word_q.delete();
            errors  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (word_q.size() == 0) begin
                    $error("unexpected result transfer: bytes %h", m_out_bytes);
                    errors++;
                end else begin
                    w = word_q.pop_front();
                    if (m_out_bytes !== w.bytes) begin
                        $error("out_bytes: expected %h actual %h", w.bytes, m_out_bytes);
                        errors++;
                    end
                    if (m_out_count !== w.count) begin
                        $error("out_count: expected %0d actual %0d", w.count, m_out_count);
                        errors++;
                    end
                    if (m_out_last !== w.last) begin
                        $error("out_last: expected %0d actual %0d", w.last, m_out_last);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) encode_pixel(s_pixel, s_row_end, s_image_end);
        end
        pending = word_q.size();
    end
endmodule

// ----- tb/sv/bmp_rle8_line_encoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// bmp_rle8_line_encoder_top_tb
// Drives pixel rows into the RLE8 encoder: directed corner rows (long runs,
// short flushes, image end) followed by random rows mixing runs and
// literals, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module bmp_rle8_line_encoder_top_tb;

    localparam int WATCHDOG = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pixel = '0;
    logic        s_row_end = 1'b0;
    logic        s_image_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_out_bytes;
    logic [3:0]  m_out_count;
    logic        m_out_last;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          done = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    bmp_rle8_line_encoder_top dut (.*);

    bmp_rle8_line_encoder_checker chk (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // random stall bursts on the result side
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        while (!done) begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    task automatic send_pixel(logic [7:0] px, logic row_end, logic img_end);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel     <= px;
        s_row_end   <= row_end;
        s_image_end <= img_end;
        @(posedge aclk iff s_ready);
    endtask

    task automatic send_run(logic [7:0] px, int len);
        for (int i = 0; i < len; i++) send_pixel(px, 1'b0, 1'b0);
    endtask

    task automatic send_row(int len, int style);
        logic [7:0] px;
        int run;
        int i = 0;
        while (i < len) begin
            px  = 8'($urandom);
            run = (style == 0) ? 1 : $urandom_range(1, style == 1 ? 3 : 9);
            for (int k = 0; k < run && i < len; k++, i++)
                send_pixel(px, i == len - 1, i == len - 1 && $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        int sent;
        int len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: single pixel row with image end
        send_pixel(8'hFF, 1'b1, 1'b1);
        // image end without row end is ignored
        send_pixel(8'h00, 1'b0, 1'b1);
        send_pixel(8'h00, 1'b1, 1'b0);
        // two literals, then a run of three, then a long run
        send_pixel(8'hA5, 1'b0, 1'b0);
        send_pixel(8'h5A, 1'b0, 1'b0);
        send_run(8'h33, 3);
        send_run(8'hC3, 5);
        send_pixel(8'h01, 1'b0, 1'b0);
        send_pixel(8'h02, 1'b0, 1'b0);
        send_pixel(8'h03, 1'b1, 1'b1);
        // random rows
        sent = 16;
        while (sent < 185) begin
            len = $urandom_range(1, 24);
            send_row(len, $urandom_range(0, 2));
            sent += len;
            if (sent > 150) quiet = 1'b1;
        end
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        done = 1'b1;
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/bre_pkg.sv
rtl/bmp_rle8_line_encoder_top.sv
tb/sv/bmp_rle8_line_encoder_checker.sv
tb/sv/bmp_rle8_line_encoder_top_tb.sv
